// File: rtl/quaternion_multiply_defines.svh
// ----------------------------------------------------------------------------
// Quaternion multiply assertion macros
// Shared macros for the concurrent checks on the quaternion multiplier ports.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_MULTIPLY_DEFINES_SVH
`define QUATERNION_MULTIPLY_DEFINES_SVH

// Check that is switched off while reset is held.
`define QM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that also holds across reset.
`define QM_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/qmul_pkg.sv
// ----------------------------------------------------------------------------
// Quaternion multiply package
// Latencies, constants and leading-zero helpers shared by the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package qmul_pkg;

  localparam int LAT_MUL = 3;
  localparam int LAT_ADD = 4;
  localparam int LAT     = LAT_MUL + 2 * LAT_ADD;

  localparam logic [31:0] QNAN    = 32'h7FC0_0000;
  localparam logic [30:0] INF_MAG = 31'h7F80_0000;

  // Sign flip for each of the four products of a lane, bit 0 being the first.
  localparam logic [3:0] NEG_W = 4'b1110;
  localparam logic [3:0] NEG_X = 4'b1000;
  localparam logic [3:0] NEG_Y = 4'b0010;
  localparam logic [3:0] NEG_Z = 4'b0100;

  function automatic logic [4:0] lzc23(input logic [22:0] v);
    logic [4:0] cnt;
    cnt = 5'd23;
    for (int i = 0; i < 23; i++) begin
      if (v[i]) cnt = 5'(22 - i);
    end
    return cnt;
  endfunction

  function automatic logic [4:0] lzc27(input logic [26:0] v);
    logic [4:0] cnt;
    cnt = 5'd27;
    for (int i = 0; i < 27; i++) begin
      if (v[i]) cnt = 5'(26 - i);
    end
    return cnt;
  endfunction

endpackage

`default_nettype wire

// File: rtl/quaternion_multiply.sv
// ----------------------------------------------------------------------------
// Quaternion multiply
// Hamilton product of two binary32 quaternions, one item per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
// Four lanes, one per result component, each run four multipliers and a
// two-level adder tree in lockstep, and one item enters every cycle while the
// pipeline is not held. The whole pipeline holds while a finished item waits
// in the output register and is not taken, so s_tready follows m_tready in
// that case.
`default_nettype none

module quaternion_multiply import qmul_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [255:0] s_tdata,  // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic      [127:0] m_tdata   // p_w, p_x, p_y, p_z
);

  logic en;
  logic [LAT-1:0] vld;
  logic [31:0] aw, ax, ay, az, bw, bx, by, bz;
  logic [3:0][31:0] a_ops;

  assign {bz, by, bx, bw, az, ay, ax, aw} = s_tdata;
  assign a_ops    = {az, ay, ax, aw};
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  qmul_lane u_lane_w (
    .clk (clk), .en (en), .x (a_ops), .y ({bz, by, bx, bw}), .neg (NEG_W),
    .p   (m_tdata[31:0])
  );

  qmul_lane u_lane_x (
    .clk (clk), .en (en), .x (a_ops), .y ({by, bz, bw, bx}), .neg (NEG_X),
    .p   (m_tdata[63:32])
  );

  qmul_lane u_lane_y (
    .clk (clk), .en (en), .x (a_ops), .y ({bx, bw, bz, by}), .neg (NEG_Y),
    .p   (m_tdata[95:64])
  );

  qmul_lane u_lane_z (
    .clk (clk), .en (en), .x (a_ops), .y ({bw, bx, by, bz}), .neg (NEG_Z),
    .p   (m_tdata[127:96])
  );

endmodule

`default_nettype wire

// File: rtl/qmul_fmul.sv
// ----------------------------------------------------------------------------
// Binary32 multiplier
// Three-stage pipelined multiply with round to nearest even and subnormals.
// ----------------------------------------------------------------------------
`default_nettype none

module qmul_fmul import qmul_pkg::*; (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic      [31:0] p
);

  logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic [4:0] sh_a, sh_b;
  logic [23:0] sig_a_c, sig_b_c;
  logic signed [9:0] exp_a_c, exp_b_c;

  logic s1_sign, s1_nan, s1_inf, s1_zero;
  logic signed [9:0] s1_exp;
  logic [23:0] s1_sig_a, s1_sig_b;

  logic s2_sign, s2_nan, s2_inf, s2_zero;
  logic signed [9:0] s2_exp;
  logic [47:0] s2_prod;

  logic [25:0] x, xs, lost_mask;
  logic signed [9:0] e_n, rs;
  logic [4:0] rsc;
  logic [7:0] efield;
  logic ovf, inc;
  logic [30:0] packed_mag;

  always_comb begin
    a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    a_zero = (a[30:0] == 31'd0);
    b_zero = (b[30:0] == 31'd0);
    sh_a   = lzc23(a[22:0]) + 5'd1;
    sh_b   = lzc23(b[22:0]) + 5'd1;
    if (a[30:23] != 8'd0) begin
      sig_a_c = {1'b1, a[22:0]};
      exp_a_c = signed'({2'b00, a[30:23]});
    end else begin
      sig_a_c = {1'b0, a[22:0]} << sh_a;
      exp_a_c = 10'sd1 - signed'({5'd0, sh_a});
    end
    if (b[30:23] != 8'd0) begin
      sig_b_c = {1'b1, b[22:0]};
      exp_b_c = signed'({2'b00, b[30:23]});
    end else begin
      sig_b_c = {1'b0, b[22:0]} << sh_b;
      exp_b_c = 10'sd1 - signed'({5'd0, sh_b});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sign  <= a[31] ^ b[31];
      s1_nan   <= a_nan | b_nan | (a_inf & b_zero) | (b_inf & a_zero);
      s1_inf   <= a_inf | b_inf;
      s1_zero  <= a_zero | b_zero;
      s1_exp   <= exp_a_c + exp_b_c - 10'sd127;
      s1_sig_a <= sig_a_c;
      s1_sig_b <= sig_b_c;
      s2_sign  <= s1_sign;
      s2_nan   <= s1_nan;
      s2_inf   <= s1_inf;
      s2_zero  <= s1_zero;
      s2_exp   <= s1_exp;
      s2_prod  <= s1_sig_a * s1_sig_b;
    end
  end

  always_comb begin
    if (s2_prod[47]) begin
      x   = {s2_prod[47:23], |s2_prod[22:0]};
      e_n = s2_exp + 10'sd1;
    end else begin
      x   = {s2_prod[46:22], |s2_prod[21:0]};
      e_n = s2_exp;
    end
    ovf = e_n > 10'sd254;
    rs  = 10'sd1 - e_n;
    if (e_n <= 10'sd0) begin
      rsc    = (rs > 10'sd26) ? 5'd26 : rs[4:0];
      efield = 8'd0;
    end else begin
      rsc    = 5'd0;
      efield = e_n[7:0];
    end
    lost_mask  = (26'd1 << rsc) - 26'd1;
    xs         = (x >> rsc) | {25'd0, |(x & lost_mask)};
    inc        = xs[1] & (xs[0] | xs[2]);
    packed_mag = {efield, xs[24:2]} + {30'd0, inc};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (s2_nan) begin
        p <= QNAN;
      end else if (s2_inf || (ovf && !s2_zero)) begin
        p <= {s2_sign, INF_MAG};
      end else if (s2_zero) begin
        p <= {s2_sign, 31'd0};
      end else begin
        p <= {s2_sign, packed_mag};
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/qmul_fadd.sv
// ----------------------------------------------------------------------------
// Binary32 adder
// Four-stage pipelined add with round to nearest even and subnormals.
// ----------------------------------------------------------------------------
`default_nettype none

module qmul_fadd import qmul_pkg::*; (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic      [31:0] s
);

  logic a_nan, b_nan, a_inf, b_inf, a_ge;
  logic [31:0] big, sml;
  logic [7:0] e_big, e_sml, d;

  logic s1_sign, s1_sub, s1_nan, s1_inf;
  logic [7:0] s1_exp;
  logic [26:0] s1_big, s1_sml;
  logic [4:0] s1_d;

  logic [26:0] al, al_mask;
  logic s2_sign, s2_sub, s2_nan, s2_inf;
  logic [7:0] s2_exp;
  logic [27:0] s2_sum;

  logic [4:0] lz;
  logic [7:0] lim, sh;
  logic [26:0] n_c;
  logic [8:0] e_c;
  logic s3_sign, s3_sub, s3_nan, s3_inf, s3_zero;
  logic [8:0] s3_exp;
  logic [26:0] s3_n;

  logic [8:0] efield;
  logic inc;
  logic [30:0] packed_mag;

  always_comb begin
    a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    a_ge  = a[30:0] >= b[30:0];
    big   = a_ge ? a : b;
    sml   = a_ge ? b : a;
    e_big = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    e_sml = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    d     = e_big - e_sml;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sign <= big[31];
      s1_sub  <= a[31] ^ b[31];
      s1_nan  <= a_nan | b_nan | (a_inf & b_inf & (a[31] ^ b[31]));
      s1_inf  <= a_inf | b_inf;
      s1_exp  <= e_big;
      s1_big  <= {big[30:23] != 8'd0, big[22:0], 3'd0};
      s1_sml  <= {sml[30:23] != 8'd0, sml[22:0], 3'd0};
      s1_d    <= (d > 8'd27) ? 5'd27 : d[4:0];
    end
  end

  always_comb begin
    al_mask = (27'd1 << s1_d) - 27'd1;
    al      = (s1_sml >> s1_d) | {26'd0, |(s1_sml & al_mask)};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_sign <= s1_sign;
      s2_sub  <= s1_sub;
      s2_nan  <= s1_nan;
      s2_inf  <= s1_inf;
      s2_exp  <= s1_exp;
      s2_sum  <= s1_sub ? ({1'b0, s1_big} - {1'b0, al}) : ({1'b0, s1_big} + {1'b0, al});
    end
  end

  always_comb begin
    lz  = lzc27(s2_sum[26:0]);
    lim = s2_exp - 8'd1;
    sh  = ({3'd0, lz} < lim) ? {3'd0, lz} : lim;
    if (s2_sum[27]) begin
      n_c = {s2_sum[27:2], s2_sum[1] | s2_sum[0]};
      e_c = {1'b0, s2_exp} + 9'd1;
    end else begin
      n_c = s2_sum[26:0] << sh;
      e_c = {1'b0, s2_exp} - {1'b0, sh};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_sign <= s2_sign;
      s3_sub  <= s2_sub;
      s3_nan  <= s2_nan;
      s3_inf  <= s2_inf;
      s3_zero <= s2_sum == 28'd0;
      s3_exp  <= e_c;
      s3_n    <= n_c;
    end
  end

  always_comb begin
    efield     = s3_n[26] ? s3_exp : 9'd0;
    inc        = s3_n[2] & (s3_n[1] | s3_n[0] | s3_n[3]);
    packed_mag = {efield[7:0], s3_n[25:3]} + {30'd0, inc};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (s3_nan) begin
        s <= QNAN;
      end else if (s3_inf || efield >= 9'd255) begin
        s <= {s3_sign, INF_MAG};
      end else if (s3_zero) begin
        s <= {s3_sign & !s3_sub, 31'd0};
      end else begin
        s <= {s3_sign, packed_mag};
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/qmul_lane.sv
// ----------------------------------------------------------------------------
// Quaternion product lane
// Four products with sign flips, merged by a two-level adder tree.
// ----------------------------------------------------------------------------
`default_nettype none

module qmul_lane import qmul_pkg::*; (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [3:0][31:0] x,
  input  wire logic [3:0][31:0] y,
  input  wire logic [3:0]       neg,
  output logic      [31:0]      p
);

  logic [3:0][31:0] prod;
  logic [3:0][31:0] term;
  logic [31:0] sum01, sum23;

  for (genvar i = 0; i < 4; i++) begin : g_mul
    qmul_fmul u_mul (
      .clk (clk),
      .en  (en),
      .a   (x[i]),
      .b   (y[i]),
      .p   (prod[i])
    );
    assign term[i] = prod[i] ^ {neg[i], 31'd0};
  end

  qmul_fadd u_add01 (.clk(clk), .en(en), .a(term[0]), .b(term[1]), .s(sum01));
  qmul_fadd u_add23 (.clk(clk), .en(en), .a(term[2]), .b(term[3]), .s(sum23));
  qmul_fadd u_merge (.clk(clk), .en(en), .a(sum01), .b(sum23), .s(p));

endmodule

`default_nettype wire

// File: rtl/qmul_checker.sv
// ----------------------------------------------------------------------------
// Quaternion multiply checker
// Port-level checks on handshake, stalling, reset and NaN encoding.
// ----------------------------------------------------------------------------
`default_nettype none

`include "quaternion_multiply_defines.svh"

module qmul_checker (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         s_tready,
  input wire logic         m_tvalid,
  input wire logic         m_tready,
  input wire logic [127:0] m_tdata
);

  logic nan_w, nan_z;

  assign nan_w = (m_tdata[30:23] == 8'hFF) && (m_tdata[22:0] != 23'd0);
  assign nan_z = (m_tdata[126:119] == 8'hFF) && (m_tdata[118:96] != 23'd0);

  `QM_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "item dropped")
  `QM_ASSERT(a_stall, s_tready == (!m_tvalid || m_tready), "input not held with pipeline")
  `QM_ASSERT_RST(a_rst, rst |=> !m_tvalid, "item after reset")
  `QM_ASSERT(a_nan_w, m_tvalid && nan_w |-> m_tdata[31:0] == 32'h7FC00000, "NaN not canonical")
  `QM_ASSERT(a_nan_z, m_tvalid && nan_z |-> m_tdata[127:96] == 32'h7FC00000, "NaN not canonical")

endmodule

bind quaternion_multiply qmul_checker u_qmul_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

// File: verif/quaternion_multiply_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quaternion multiply checker
// Watches both streams of the quaternion multiplier, computes the binary32
// Hamilton product of every accepted item and compares it with the results.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_multiply_checker (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  input  wire logic         s_tready,
  input  wire logic [255:0] s_tdata,  // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z
  input  wire logic         m_tvalid,
  input  wire logic         m_tready,
  input  wire logic [127:0] m_tdata,  // p_w, p_x, p_y, p_z
  output int                errors,
  output int                pending
);

  localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;

  logic [127:0] product_queue[$];

  function automatic logic [31:0] fp_join(logic s, int e, logic [31:0] m);
    return {s, 31'b0} + (32'(e) << 23) + m;
  endfunction

  function automatic int lead_zeros(logic [31:0] v);
    int n;
    n = 0;
    while (n < 32 && !v[31]) begin
      v = v << 1;
      n++;
    end
    return n;
  endfunction

  function automatic logic [31:0] sticky_shr(logic [31:0] a, int d);
    if (d <= 0) return a;
    if (d < 31) return (a >> d) | 32'((a << (32 - d)) != 0);
    return 32'(a != 0);
  endfunction

  // Significand has its integer bit at bit 30 and seven guard bits.
  function automatic logic [31:0] fp_round(logic s, int e, logic [31:0] m);
    logic [6:0] rb;
    rb = m[6:0];
    if ($unsigned(e) >= 32'hFD) begin
      if (e < 0) begin
        m = sticky_shr(m, -e);
        e = 0;
        rb = m[6:0];
      end else if (e > 253 || m + 32'h40 >= 32'h8000_0000) begin
        return {s, 31'h7F80_0000};
      end
    end
    m = (m + 32'h40) >> 7;
    if (rb == 7'h40) m[0] = 1'b0;
    if (m == 0) e = 0;
    return fp_join(s, e, m);
  endfunction

  function automatic logic [31:0] fp_norm_round(logic s, int e, logic [31:0] m);
    int sh;
    sh = lead_zeros(m) - 1;
    e -= sh;
    if (sh >= 7 && $unsigned(e) < 32'hFD) return fp_join(s, m != 0 ? e : 0, m << (sh - 7));
    return fp_round(s, e, m << sh);
  endfunction

  function automatic logic [31:0] fp_mul(logic [31:0] a, logic [31:0] b);
    logic s;
    int ea, eb, ez, sh;
    logic [31:0] ma, mb, mz;
    logic [63:0] p;
    s = a[31] ^ b[31];
    ea = int'(a[30:23]);
    eb = int'(b[30:23]);
    ma = {9'b0, a[22:0]};
    mb = {9'b0, b[22:0]};
    if (ea == 255) begin
      if (ma != 0 || (eb == 255 && mb != 0)) return CANON_NAN;
      if (eb == 0 && mb == 0) return CANON_NAN;
      return {s, 31'h7F80_0000};
    end
    if (eb == 255) begin
      if (mb != 0) return CANON_NAN;
      if (ea == 0 && ma == 0) return CANON_NAN;
      return {s, 31'h7F80_0000};
    end
    if (ea == 0) begin
      if (ma == 0) return {s, 31'b0};
      sh = lead_zeros(ma) - 8;
      ea = 1 - sh;
      ma = ma << sh;
    end
    if (eb == 0) begin
      if (mb == 0) return {s, 31'b0};
      sh = lead_zeros(mb) - 8;
      eb = 1 - sh;
      mb = mb << sh;
    end
    ez = ea + eb - 127;
    ma = (ma | 32'h80_0000) << 7;
    mb = (mb | 32'h80_0000) << 8;
    p = {32'b0, ma} * {32'b0, mb};
    mz = p[63:32] | 32'(p[31:0] != 0);
    if (mz < 32'h4000_0000) begin
      ez--;
      mz = mz << 1;
    end
    return fp_round(s, ez, mz);
  endfunction

  function automatic logic [31:0] fp_add_same(logic [31:0] a, logic [31:0] b);
    logic s;
    int ea, eb, d, ez;
    logic [31:0] ma, mb, mz;
    s = a[31];
    ea = int'(a[30:23]);
    eb = int'(b[30:23]);
    ma = {9'b0, a[22:0]};
    mb = {9'b0, b[22:0]};
    d = ea - eb;
    if (d == 0) begin
      if (ea == 0) return a + mb;
      if (ea == 255) return (ma | mb) != 0 ? CANON_NAN : a;
      ez = ea;
      mz = 32'h0100_0000 + ma + mb;
      if (!mz[0] && ez < 254) return fp_join(s, ez, mz >> 1);
      mz = mz << 6;
    end else begin
      ma = ma << 6;
      mb = mb << 6;
      if (d < 0) begin
        if (eb == 255) return mb != 0 ? CANON_NAN : fp_join(s, 255, 0);
        ez = eb;
        ma = ma + (ea != 0 ? 32'h2000_0000 : ma);
        ma = sticky_shr(ma, -d);
      end else begin
        if (ea == 255) return ma != 0 ? CANON_NAN : a;
        ez = ea;
        mb = mb + (eb != 0 ? 32'h2000_0000 : mb);
        mb = sticky_shr(mb, d);
      end
      mz = 32'h2000_0000 + ma + mb;
      if (mz < 32'h4000_0000) begin
        ez--;
        mz = mz << 1;
      end
    end
    return fp_round(s, ez, mz);
  endfunction

  function automatic logic [31:0] fp_sub_diff(logic [31:0] a, logic [31:0] b);
    logic s;
    int ea, eb, d, ez, sh, diff;
    logic [31:0] ma, mb, mx, my;
    s = a[31];
    ea = int'(a[30:23]);
    eb = int'(b[30:23]);
    ma = {9'b0, a[22:0]};
    mb = {9'b0, b[22:0]};
    d = ea - eb;
    if (d == 0) begin
      if (ea == 255) return CANON_NAN;
      diff = int'(ma) - int'(mb);
      if (diff == 0) return 32'b0;
      if (ea != 0) ea--;
      if (diff < 0) begin
        s = ~s;
        diff = -diff;
      end
      sh = lead_zeros(32'(diff)) - 8;
      ez = ea - sh;
      if (ez < 0) begin
        sh = ea;
        ez = 0;
      end
      return fp_join(s, ez, 32'(diff) << sh);
    end
    ma = ma << 7;
    mb = mb << 7;
    if (d < 0) begin
      s = ~s;
      if (eb == 255) return mb != 0 ? CANON_NAN : fp_join(s, 255, 0);
      ez = eb - 1;
      mx = mb | 32'h4000_0000;
      my = ma + (ea != 0 ? 32'h4000_0000 : ma);
      d = -d;
    end else begin
      if (ea == 255) return ma != 0 ? CANON_NAN : a;
      ez = ea - 1;
      mx = ma | 32'h4000_0000;
      my = mb + (eb != 0 ? 32'h4000_0000 : mb);
    end
    return fp_norm_round(s, ez, mx - sticky_shr(my, d));
  endfunction

  function automatic logic [31:0] fp_add(logic [31:0] a, logic [31:0] b);
    if (a[31] == b[31]) return fp_add_same(a, b);
    return fp_sub_diff(a, b);
  endfunction

  // Products in the order p1..p4; a set bit in neg flips that product's sign.
  function automatic logic [31:0] lane_sum(logic [31:0] x[4], logic [31:0] y[4],
                                           logic [3:0] neg);
    logic [31:0] t[4];
    for (int i = 0; i < 4; i++) t[i] = fp_mul(x[i], y[i]) ^ {neg[i], 31'b0};
    return fp_add(fp_add(t[0], t[1]), fp_add(t[2], t[3]));
  endfunction

  function automatic logic [127:0] hamilton_product(logic [255:0] d);
    logic [31:0] aw, ax, ay, az, bw, bx, by, bz;
    logic [31:0] pw, px, py, pz;
    {bz, by, bx, bw, az, ay, ax, aw} = d;
    pw = lane_sum('{aw, ax, ay, az}, '{bw, bx, by, bz}, 4'b1110);
    px = lane_sum('{aw, ax, ay, az}, '{bx, bw, bz, by}, 4'b1000);
    py = lane_sum('{aw, ax, ay, az}, '{by, bz, bw, bx}, 4'b0010);
    pz = lane_sum('{aw, ax, ay, az}, '{bz, by, bx, bw}, 4'b0100);
    return {pz, py, px, pw};
  endfunction

  initial errors = 0;
  initial pending = 0;

  always @(posedge clk) begin
    logic [127:0] want;
    if (!rst) begin
      if (s_tvalid && s_tready) product_queue.push_back(hamilton_product(s_tdata));
      if (m_tvalid && m_tready) begin
        if (product_queue.size() == 0) begin
          errors <= errors + 1;
          if (errors < 10) $display("unexpected result %h", m_tdata);
        end else begin
          want = product_queue.pop_front();
          if (want !== m_tdata) begin
            errors <= errors + 1;
            if (errors < 10) begin
              for (int i = 0; i < 4; i++) begin
                if (want[32*i +: 32] !== m_tdata[32*i +: 32])
                  $display("component %0d: expected %h, got %h", i, want[32*i +: 32],
                           m_tdata[32*i +: 32]);
              end
            end
          end
        end
      end
      pending <= product_queue.size();
    end
  end

endmodule

`default_nettype wire

// File: verif/quaternion_multiply_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quaternion multiply testbench
// Streams directed and random binary32 quaternion pairs into the multiplier
// with random gaps and back-pressure, and reports the checker's verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_multiply_test import qmul_pkg::*;;

  localparam logic [31:0] POS_INF = 32'h7F80_0000;
  localparam logic [31:0] NEG_INF = 32'hFF80_0000;
  localparam logic [31:0] ONE     = 32'h3F80_0000;
  localparam logic [31:0] MAX_FIN = 32'h7F7F_FFFF;
  localparam logic [31:0] MIN_SUB = 32'h0000_0001;
  localparam logic [31:0] NEG_ZERO = 32'h8000_0000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [255:0] s_tdata = '0;  // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [127:0] m_tdata;       // p_w, p_x, p_y, p_z
  int           errors;
  int           pending;
  int           send_idle_pct = 12;
  int           cycle = 0;

  always #5 clk = ~clk;

  quaternion_multiply dut (.*);

  quaternion_multiply_checker checker_i (.*);

  always @(posedge clk) cycle <= cycle + 1;

  // Receiver holds off for a long stretch early, then never idles for another one.
  always @(posedge clk) begin
    if (cycle >= 120 && cycle < 200) m_tready <= 1'b0;
    else if (cycle >= 400 && cycle < 700) m_tready <= 1'b1;
    else m_tready <= $urandom_range(99) >= 12;
  end

  task automatic send_item(input logic [255:0] d);
    logic rdy;
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata <= d;
    do begin
      @(negedge clk);
      rdy = s_tready;
      @(posedge clk);
    end while (!rdy);
  endtask

  function automatic logic [31:0] rand_component();
    logic [31:0] pool[8] = '{32'h0, NEG_ZERO, POS_INF, NEG_INF, 32'h7FC0_0001,
                             32'hFFFF_FFFF, MAX_FIN, MIN_SUB};
    case ($urandom_range(9))
      0: return pool[$urandom_range(7)];
      1: return {1'($urandom), 8'h00, 23'($urandom)};
      2: return {1'($urandom), 8'($urandom_range(254, 240)), 23'($urandom)};
      3: return $urandom;
      default: return {1'($urandom), 8'($urandom_range(134, 120)), 23'($urandom)};
    endcase
  endfunction

  function automatic logic [255:0] rand_pair();
    logic [31:0] c[8];
    for (int i = 0; i < 8; i++) c[i] = rand_component();
    // Make the first two products of the scalar part cancel exactly: aw*ax - ax*aw.
    if ($urandom_range(7) == 0) begin
      c[4] = c[1];
      c[5] = c[0];
    end
    return {c[7], c[6], c[5], c[4], c[3], c[2], c[1], c[0]};
  endfunction

  initial begin
    logic [255:0] directed[$];
    directed.push_back('0);
    directed.push_back('1);
    directed.push_back({8{NEG_ZERO}});
    directed.push_back({{4{32'h0}}, {4{NEG_ZERO}}});
    directed.push_back({32'h0, 32'h0, 32'h0, ONE, 32'h4049_0FDB, 32'hC020_0000,
                        32'h3E80_0000, 32'hBF00_0000});
    directed.push_back({{4{32'h0}}, {4{POS_INF}}});
    directed.push_back({32'h0, 32'h0, ONE, ONE, 32'h0, 32'h0, POS_INF, POS_INF});
    directed.push_back({{4{ONE}}, {4{32'h7FA0_1234}}});
    directed.push_back({{4{32'hFFC0_0001}}, {4{ONE}}});
    directed.push_back({{4{MAX_FIN}}, {4{MAX_FIN}}});
    directed.push_back({{4{32'hFF7F_FFFF}}, {4{MAX_FIN}}});
    directed.push_back({{4{ONE}}, {4{MIN_SUB}}});
    directed.push_back({{4{MIN_SUB}}, {4{MIN_SUB}}});
    directed.push_back({{4{32'h0000_0100}}, {4{32'h3F00_0000}}});
    directed.push_back({{4{32'h007F_FFFF}}, {4{32'h3FFF_FFFF}}});
    directed.push_back({{4{32'h3F80_0001}}, {4{32'h3F80_0001}}});
    directed.push_back({32'h0, 32'h0, 32'h4040_0000, 32'h4000_0000,
                        32'h0, 32'h0, 32'h4000_0000, 32'h4040_0000});
    directed.push_back({{4{32'h0080_0000}}, {4{32'h3F7F_FFFF}}});
    directed.push_back({{4{32'h7F00_0000}}, {4{32'h4000_0000}}});
    directed.push_back({{2{32'h3F80_0000, 32'hBF80_0000}}, {2{POS_INF, NEG_INF}}});
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    foreach (directed[i]) send_item(directed[i]);
    for (int n = 0; n < 400; n++) begin
      send_idle_pct = (n >= 150 && n < 250) ? 0 : 12;
      send_item(rand_pair());
    end
    s_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (LAT + 20) @(posedge clk);
    if (errors == 0 && pending == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #1ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

`default_nettype wire
